FILE: sv/scp_pkg.sv
// scp_pkg: shared types, constants and character tables for the servo command parser
// no dependencies; compiled first
package scp_pkg;

  // register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FS  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] PULSE_MIN_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] PULSE_MAX_RST = 16'd2500;
  localparam logic [CFG_DATA_W-1:0] ANGLE_FS_RST  = 16'd180;

  // payload widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned ANGLE_W = 8;

  // characters
  localparam logic [BYTE_W-1:0] CH_TERM  = 8'h68;  // 'h'
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  localparam int unsigned LIGHT_LEN  = 5;
  localparam int unsigned PREFIX_LEN = 6;

  // angle limits
  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] ANGLE_RST = 8'd90;
  localparam logic [ANGLE_W-1:0] VALUE_SAT = 8'd255;

  // result kinds
  localparam logic KIND_LIGHT = 1'b0;
  localparam logic KIND_PULSE = 1'b1;

  // serial divider geometry: angle (8) times span (16) over a 16 bit divisor
  localparam int unsigned DIV_NUM_W = ANGLE_W + PULSE_W;
  localparam int unsigned DIV_DEN_W = PULSE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef struct packed {
    logic take;   // accepted byte that is not the terminator
    logic clear;  // accepted terminator, start a new line
  } line_ctl_t;

  typedef struct packed {
    logic               light_hit;
    logic               angle_hit;
    logic               negative;
    logic [ANGLE_W-1:0] value;
  } line_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [BYTE_W-1:0] light_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h4C;  // L
      3'd1:    c = 8'h49;  // I
      3'd2:    c = 8'h47;  // G
      3'd3:    c = 8'h48;  // H
      3'd4:    c = 8'h54;  // T
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h41;  // A
      3'd1:    c = 8'h4E;  // N
      3'd2:    c = 8'h47;  // G
      3'd3:    c = 8'h4C;  // L
      3'd4:    c = 8'h45;  // E
      3'd5:    c = 8'h3D;  // =
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/scp_if.sv
// scp_if: valid/ready stream interfaces for received bytes and results
// depends on scp_pkg
interface scp_byte_if import scp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scp_result_if import scp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [PULSE_W-1:0] pulse_value;
  logic               angle_taken;
  logic [ANGLE_W-1:0] held_angle_out;

  modport source (output valid, output result_kind, output pulse_value,
                  output angle_taken, output held_angle_out, input ready);
  modport sink (input valid, input result_kind, input pulse_value,
                input angle_taken, input held_angle_out, output ready);
endinterface

FILE: sv/scp_line.sv
// scp_line: per-line state, keyword match and atoi-style number scan
// depends on scp_pkg
module scp_line import scp_pkg::*; #(
  parameter int unsigned LINE_BYTES = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  line_ctl_t         ctl,
  input  logic [BYTE_W-1:0] rx_byte,
  output line_stat_t        stat
);

  localparam int unsigned CW = $clog2(LINE_BYTES);
  localparam logic [CW-1:0] COUNT_LAST = CW'(LINE_BYTES - 1);

  typedef enum logic [2:0] {
    NP_SPACE  = 3'b001,
    NP_DIGITS = 3'b010,
    NP_DONE   = 3'b100
  } num_phase_t;

  logic [CW-1:0]      char_count, char_count_next;
  logic               light_match, light_match_next;
  logic               prefix_match, prefix_match_next;
  num_phase_t         number_phase, number_phase_next;
  logic               number_negative, number_negative_next;
  logic [ANGLE_W-1:0] number_value, number_value_next;
  logic               line_overrun, line_overrun_next;

  logic               is_white, is_digit, is_sign;
  logic [11:0]        acc;
  logic [ANGLE_W-1:0] acc_sat;

  assign is_white = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign acc = {1'b0, number_value, 3'b000} + {3'b000, number_value, 1'b0}
             + {4'b0000, rx_byte - CH_ZERO};
  assign acc_sat = (acc > 12'(VALUE_SAT)) ? VALUE_SAT : acc[ANGLE_W-1:0];

  always_comb begin
    char_count_next      = char_count;
    light_match_next     = light_match;
    prefix_match_next    = prefix_match;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    number_value_next    = number_value;
    line_overrun_next    = line_overrun;
    if (ctl.clear) begin
      char_count_next      = '0;
      light_match_next     = 1'b1;
      prefix_match_next    = 1'b1;
      number_phase_next    = NP_SPACE;
      number_negative_next = 1'b0;
      number_value_next    = '0;
      line_overrun_next    = 1'b0;
    end else if (ctl.take) begin
      if (line_overrun || (char_count >= COUNT_LAST)) begin
        line_overrun_next = 1'b1;
      end else begin
        if (char_count < CW'(LIGHT_LEN)) begin
          if (rx_byte != light_char(char_count[2:0])) light_match_next = 1'b0;
        end else if (char_count == CW'(LIGHT_LEN)) begin
          if (rx_byte != CH_NUL) light_match_next = 1'b0;
        end
        if (char_count < CW'(PREFIX_LEN)) begin
          if (rx_byte != prefix_char(char_count[2:0])) prefix_match_next = 1'b0;
        end else if (prefix_match) begin
          case (number_phase)
            NP_SPACE: begin
              if (is_sign) begin
                number_negative_next = (rx_byte == CH_MINUS);
                number_phase_next    = NP_DIGITS;
              end else if (!is_white) begin
                if (is_digit) begin
                  number_value_next = acc_sat;
                  number_phase_next = NP_DIGITS;
                end else begin
                  number_phase_next = NP_DONE;
                end
              end
            end
            NP_DIGITS: begin
              if (is_digit) number_value_next = acc_sat;
              else number_phase_next = NP_DONE;
            end
            default: begin
            end
          endcase
        end
        char_count_next = char_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= '0;
      light_match     <= 1'b1;
      prefix_match    <= 1'b1;
      number_phase    <= NP_SPACE;
      number_negative <= 1'b0;
      number_value    <= '0;
      line_overrun    <= 1'b0;
    end else begin
      char_count      <= char_count_next;
      light_match     <= light_match_next;
      prefix_match    <= prefix_match_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      number_value    <= number_value_next;
      line_overrun    <= line_overrun_next;
    end
  end

  always_comb begin
    stat.light_hit = !line_overrun && light_match && (char_count >= CW'(LIGHT_LEN));
    stat.angle_hit = !line_overrun && !stat.light_hit && prefix_match
                   && (char_count >= CW'(PREFIX_LEN));
    stat.negative  = number_negative;
    stat.value     = number_value;
  end

endmodule

FILE: sv/scp_divu.sv
// scp_divu: restoring serial divider, one quotient bit per cycle
// depends on scp_pkg
module scp_divu import scp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output div_stat_t            stat,
  output logic [DIV_NUM_W-1:0] quotient
);

  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic [DIV_DEN_W+1:0] diff;
  logic                 fits;

  // trial subtract of the shifted remainder
  assign diff = {1'b0, rem, quo[DIV_NUM_W-1]} - {2'b00, dsr};
  assign fits = !diff[DIV_DEN_W+1];

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DIV_NUM_W-2:0], fits};
      rem <= fits ? diff[DIV_DEN_W-1:0] : {rem[DIV_DEN_W-2:0], quo[DIV_NUM_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1)) && !start;
      if (start) cnt <= DIV_CNT_W'(DIV_NUM_W);
      else if (cnt != '0) cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quotient  = quo;

endmodule

FILE: sv/servo_command_parser.sv
// servo_command_parser: top level, byte sequencer, config registers, result register
// depends on scp_pkg, scp_if, scp_line, scp_divu
//
//   port       dir  payload                                              flow
//   byte_ch    in   rx_byte[7:0]                                         valid/ready
//   result_ch  out  result_kind, pulse_value[15:0], angle_taken,         valid/ready
//                   held_angle_out[7:0]
//   cfg_*      in   cfg_index[1:0], cfg_data[15:0] on cfg_we             write only
//
// a byte other than 'h' is taken while idle and ready stays high
// a terminator of a light line leads straight to output; one of an angle line leads to
//   one multiply, then a divider step per quotient bit, the done flag and the output
// ready is low from the terminator until its result is moved to the output register
// the output register holds a result until taken; the next byte is accepted meanwhile
// rst is synchronous; angle resets to 90 and the registers to 500, 2500, 180
module servo_command_parser import scp_pkg::*; #(
  parameter int unsigned LINE_BYTES = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  scp_byte_if.sink              byte_ch,
  scp_result_if.source          result_ch
);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } seq_state_t;

  seq_state_t state, state_next;

  // configuration registers
  logic [PULSE_W-1:0] pulse_min, pulse_max, angle_full_scale;

  // line parser
  line_ctl_t  line_ctl;
  line_stat_t line_stat;

  // held angle and staged result
  logic [ANGLE_W-1:0] held_angle;
  logic               res_kind;
  logic               res_taken;
  logic               taken;

  // divider hookup
  logic [PULSE_W-1:0]   span;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] product;
  logic                 div_start;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] quotient;

  // pulse assembly
  logic [PULSE_W:0]   pulse_sum;
  logic [PULSE_W-1:0] pulse_final;

  // output register
  logic               out_valid;
  logic               out_kind;
  logic [PULSE_W-1:0] out_pulse;
  logic               out_taken;
  logic [ANGLE_W-1:0] out_angle;
  logic               in_fire;
  logic               is_term;
  logic               out_load;

  assign byte_ch.ready = (state == S_IDLE);
  assign in_fire = byte_ch.valid && byte_ch.ready;
  assign is_term = (byte_ch.rx_byte == CH_TERM);

  assign line_ctl.take  = in_fire && !is_term;
  assign line_ctl.clear = in_fire && is_term;

  scp_line #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .ctl     (line_ctl),
    .rx_byte (byte_ch.rx_byte),
    .stat    (line_stat)
  );

  // config writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min        <= PULSE_MIN_RST;
      pulse_max        <= PULSE_MAX_RST;
      angle_full_scale <= ANGLE_FS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_MIN: pulse_min        <= cfg_data;
        REG_PULSE_MAX: pulse_max        <= cfg_data;
        REG_ANGLE_FS:  angle_full_scale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // in range, and a minus sign only on zero
  assign taken = (line_stat.value <= ANGLE_MAX) && (!line_stat.negative || (line_stat.value == '0));

  // mapping operands; a span below zero clamps to zero, a zero divisor acts as one
  assign span    = (pulse_max >= pulse_min) ? (pulse_max - pulse_min) : '0;
  assign div_den = (angle_full_scale == '0) ? DIV_DEN_W'(1) : angle_full_scale;
  assign product = DIV_NUM_W'(held_angle) * DIV_NUM_W'(span);
  assign div_start = (state == S_MUL);

  scp_divu u_divu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // pulse_min plus the quotient, saturating at full 16 bits
  assign pulse_sum = {1'b0, pulse_min} + {1'b0, quotient[PULSE_W-1:0]};
  assign pulse_final = ((quotient[DIV_NUM_W-1:PULSE_W] != '0) || pulse_sum[PULSE_W])
                     ? {PULSE_W{1'b1}} : pulse_sum[PULSE_W-1:0];

  assign out_load = (state == S_OUT) && (!out_valid || result_ch.ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && is_term) begin
          if (line_stat.light_hit) state_next = S_OUT;
          else if (line_stat.angle_hit) state_next = S_MUL;
        end
      end
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (div_stat.done) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_angle <= ANGLE_RST;
    end else begin
      state <= state_next;
      if (in_fire && is_term && line_stat.angle_hit && taken) held_angle <= line_stat.value;
    end
  end

  // staged result kind and taken flag, captured on the terminator
  always_ff @(posedge clk) begin
    if (in_fire && is_term) begin
      res_kind  <= line_stat.light_hit ? KIND_LIGHT : KIND_PULSE;
      res_taken <= line_stat.angle_hit && taken;
    end
  end

  // output register: loads from the staged result when free or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= res_kind;
      if (res_kind == KIND_LIGHT) begin
        out_pulse <= '0;
        out_taken <= 1'b0;
        out_angle <= '0;
      end else begin
        out_pulse <= pulse_final;
        out_taken <= res_taken;
        out_angle <= held_angle;
      end
    end
  end

  assign result_ch.valid          = out_valid;
  assign result_ch.result_kind    = out_kind;
  assign result_ch.pulse_value    = out_pulse;
  assign result_ch.angle_taken    = out_taken;
  assign result_ch.held_angle_out = out_angle;

`ifndef SYNTH
  // the held angle always stays a legal servo angle
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    held_angle <= ANGLE_MAX)
    else $error("held angle out of range");

  // a byte that is not a terminator never leaves the idle state
  a_plain_byte_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_term) |=> (state == S_IDLE))
    else $error("plain byte left idle");

  // the divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // the divider runs only inside the divide state
  a_div_busy_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider busy outside divide state");

  // a new result appears only out of the output state
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result without output state");
`endif

endmodule

FILE: bench/scp_checker.sv
`timescale 1ns / 100ps
// scp_checker: watches the byte, result and register ports of the servo command parser,
// predicts each result and compares it field by field; depends on scp_pkg and scp_if
module scp_checker import scp_pkg::*; #(
  parameter int unsigned LINE_BYTES = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  scp_byte_if                   byte_ch,
  scp_result_if                 result_ch,
  output int                    mismatches,
  output int                    outstanding,
  output int                    light_seen,
  output int                    pulse_seen,
  output int                    stored_seen
);

  typedef enum logic [1:0] {NUM_SPACE, NUM_DIGITS, NUM_DONE} num_phase_t;

  typedef struct packed {
    logic               kind;
    logic [PULSE_W-1:0] pulse;
    logic               taken;
    logic [ANGLE_W-1:0] angle;
  } servo_result_t;

  localparam logic [BYTE_W-1:0] LIGHT_WORD [LIGHT_LEN]  = '{"L", "I", "G", "H", "T"};
  localparam logic [BYTE_W-1:0] ANGLE_WORD [PREFIX_LEN] = '{"A", "N", "G", "L", "E", "="};

  // register copies
  logic [PULSE_W-1:0] pulse_lo, pulse_hi, full_scale;

  // line scanner state
  logic [4:0]         line_pos;
  logic               light_ok, prefix_ok, too_long, num_negative;
  num_phase_t         num_phase;
  logic [ANGLE_W-1:0] num_value;
  logic [ANGLE_W-1:0] held;

  servo_result_t pending_results[$];
  int errors, lights, pulses, stored;

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  task automatic restart_line();
    line_pos     = '0;
    light_ok     = 1'b1;
    prefix_ok    = 1'b1;
    too_long     = 1'b0;
    num_negative = 1'b0;
    num_phase    = NUM_SPACE;
    num_value    = '0;
  endtask

  task automatic scan_number(input logic [BYTE_W-1:0] b);
    int unsigned acc;
    if (num_phase == NUM_SPACE) begin
      if (is_blank(b)) return;
      if (b == CH_PLUS || b == CH_MINUS) begin
        num_negative = (b == CH_MINUS);
        num_phase    = NUM_DIGITS;
        return;
      end
      num_phase = NUM_DIGITS;
    end
    if (num_phase == NUM_DIGITS) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        acc       = num_value * 10 + (b - CH_ZERO);
        num_value = (acc > VALUE_SAT) ? VALUE_SAT : acc[ANGLE_W-1:0];
      end else begin
        num_phase = NUM_DONE;
      end
    end
  endtask

  task automatic scan_char(input logic [BYTE_W-1:0] b);
    // a light line may carry a string terminator right after the word
    if (line_pos < LIGHT_LEN) begin
      if (b != LIGHT_WORD[line_pos]) light_ok = 1'b0;
    end else if (line_pos == LIGHT_LEN) begin
      if (b != CH_NUL) light_ok = 1'b0;
    end
    if (line_pos < PREFIX_LEN) begin
      if (b != ANGLE_WORD[line_pos]) prefix_ok = 1'b0;
    end else if (prefix_ok) begin
      scan_number(b);
    end
    line_pos = line_pos + 1'b1;
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    servo_result_t      r;
    logic               taken;
    logic [PULSE_W-1:0] span, divisor;
    logic [31:0]        total;
    if (b != CH_TERM) begin
      if (too_long || line_pos >= LINE_BYTES - 1) too_long = 1'b1;
      else scan_char(b);
      return;
    end
    r = '0;
    if (!too_long) begin
      if (light_ok && line_pos >= LIGHT_LEN) begin
        r.kind = KIND_LIGHT;
        pending_results.push_back(r);
        lights++;
      end else if (prefix_ok && line_pos >= PREFIX_LEN) begin
        taken = (num_value <= ANGLE_MAX) && (!num_negative || num_value == 0);
        if (taken) begin
          held = num_value;
          stored++;
        end
        span    = (pulse_hi >= pulse_lo) ? pulse_hi - pulse_lo : '0;
        divisor = (full_scale == 0) ? 16'd1 : full_scale;
        total   = pulse_lo + (held * span) / divisor;
        r.kind  = KIND_PULSE;
        r.pulse = (total > 32'hFFFF) ? '1 : total[PULSE_W-1:0];
        r.taken = taken;
        r.angle = held;
        pending_results.push_back(r);
        pulses++;
      end
    end
    restart_line();
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    servo_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got kind %0d pulse %0d taken %0d angle %0d",
               $time, result_ch.result_kind, result_ch.pulse_value, result_ch.angle_taken,
               result_ch.held_angle_out);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("result_kind", want.kind, result_ch.result_kind);
    compare_field("pulse_value", want.pulse, result_ch.pulse_value);
    compare_field("angle_taken", want.taken, result_ch.angle_taken);
    compare_field("held_angle_out", want.angle, result_ch.held_angle_out);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pulse_lo   = PULSE_MIN_RST;
      pulse_hi   = PULSE_MAX_RST;
      full_scale = ANGLE_FS_RST;
      held       = ANGLE_RST;
      restart_line();
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PULSE_MIN: pulse_lo = cfg_data;
          REG_PULSE_MAX: pulse_hi = cfg_data;
          REG_ANGLE_FS:  full_scale = cfg_data;
          default: ;
        endcase
      end
      if (byte_ch.valid && byte_ch.ready) predict_byte(byte_ch.rx_byte);
      if (result_ch.valid && result_ch.ready) check_result();
    end
    outstanding <= pending_results.size();
    mismatches  <= errors;
    light_seen  <= lights;
    pulse_seen  <= pulses;
    stored_seen <= stored;
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset, byte and register stimulus and the verdict for servo_command_parser
// depends on scp_pkg, scp_if, scp_checker and the parser rtl
module tb_top import scp_pkg::*; ();

  localparam int unsigned LINE_BYTES = 20;
  localparam int RANDOM_BYTES   = 1600;
  localparam int RANDOM_PHASES  = 6;
  localparam int SETTLE_CYCLES  = 40;    // longer than the slowest terminator
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake or write
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // index with no register behind it

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scp_byte_if   byte_ch ();
  scp_result_if result_ch ();

  int mismatches, outstanding, light_seen, pulse_seen, stored_seen;

  // steady: no idling on either side, used for the last part of the run
  bit steady;
  // calm_line: the current line goes out without gaps
  bit calm_line;
  int bytes_sent;
  int settings;
  int stuck_cycles;
  logic [BYTE_W-1:0] text_q[$];

  servo_command_parser #(.LINE_BYTES(LINE_BYTES)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  // predicts and compares every result, reports the count of mismatches
  scp_checker #(.LINE_BYTES(LINE_BYTES)) result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_ch     (byte_ch),
    .result_ch   (result_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .light_seen  (light_seen),
    .pulse_seen  (pulse_seen),
    .stored_seen (stored_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: ready runs interleaved with stall bursts
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady || $urandom_range(0, 2) != 0) begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(posedge clk);
      end
    end
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (rst || cfg_we || (byte_ch.valid && byte_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // one byte; returns at the edge where it is accepted, valid still high
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    if (!steady && !calm_line && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // the collected text, then the terminator
  task automatic send_line();
    foreach (text_q[i]) push_byte(text_q[i]);
    push_byte(CH_TERM);
    text_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [BYTE_W-1:0] pick_blank();
    if ($urandom_range(0, 6) == 0) return CH_SPACE;
    return $urandom_range(CH_TAB, CH_CR);
  endfunction

  // atoi style tail: blanks, a sign, digits, sometimes junk after them
  task automatic add_number_tail();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(pick_blank());
    case ($urandom_range(0, 5))
      0: text_q.push_back(CH_MINUS);
      1: text_q.push_back(CH_PLUS);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: ;  // no digits at all
      1: add_text($sformatf("%0d", $urandom_range(181, 99999)));
      2: add_text($sformatf("%0d", $urandom_range(170, 190)));
      default: add_text($sformatf("%0d", $urandom_range(0, 180)));
    endcase
    if ($urandom_range(0, 4) == 0) text_q.push_back($urandom_range(0, 255));
  endtask

  // register writes only once the block has gone quiet
  task automatic set_config(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi,
                            input logic [PULSE_W-1:0] scale);
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= $urandom_range(0, 65535);
    @(posedge clk);
    cfg_index <= REG_PULSE_MIN;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_PULSE_MAX;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_ANGLE_FS;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // one random line, mostly well formed commands with random content
  task automatic random_line();
    int pick;
    calm_line = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 19);
    if (pick <= 8 || pick >= 18) begin
      add_text("ANGLE=");
      add_number_tail();
      // a string terminator cuts the number short
      if ($urandom_range(0, 9) == 0) text_q.insert($urandom_range(6, text_q.size()), CH_NUL);
    end else if (pick <= 11) begin
      add_text("LIGHT");
      case ($urandom_range(0, 5))
        0, 1: begin
          text_q.push_back(CH_NUL);
          repeat ($urandom_range(0, 3)) text_q.push_back($urandom_range(0, 255));
        end
        2: text_q.push_back($urandom_range(0, 255));
        default: ;
      endcase
    end else if (pick <= 13) begin
      // near miss: a well formed command with one byte changed
      if (pick == 12) add_text("LIGHT");
      else add_text("ANGLE=90");
      text_q[$urandom_range(0, text_q.size() - 1)] = $urandom_range(0, 255);
    end else if (pick <= 15) begin
      repeat ($urandom_range(0, 8)) text_q.push_back($urandom_range(0, 255));
    end else if (pick == 16) begin
      // lengths around the buffer size
      add_text("ANGLE=");
      repeat ($urandom_range(11, 17)) text_q.push_back(CH_ZERO + $urandom_range(0, 9));
    end else begin
      if ($urandom_range(0, 1) == 0) add_text("ANGL");
      else add_text("LIGH");
    end
    send_line();
  endtask

  initial begin
    int target;
    logic [PULSE_W-1:0] lo;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_PULSE_MIN;
    cfg_data        <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= '0;
    steady     = 1'b0;
    calm_line  = 1'b0;
    bytes_sent = 0;
    settings   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed lines at reset register values
    add_text("LIGHT");
    send_line();
    add_text("LIGHT");                          // light word ended by a string terminator
    text_q.push_back(CH_NUL);
    add_text("xy");
    send_line();
    add_text("LIGHTS");                         // one byte too many, no result
    send_line();
    send_line();                                // empty line
    add_text("ANGLE=");                         // no digits reads as zero
    send_line();
    add_text("ANGLE=180");
    send_line();
    add_text("ANGLE=181");                      // out of range, held angle kept
    send_line();
    for (int c = CH_TAB; c <= CH_CR; c++) text_q.push_back(c);
    text_q.push_front(CH_SPACE);
    text_q = {"A", "N", "G", "L", "E", "=", text_q};
    add_text("+45");                            // every blank, then a plus sign
    send_line();
    add_text("ANGLE=-0");                       // negative zero is stored
    send_line();
    add_text("ANGLE=-7");
    send_line();
    add_text("ANGLE=98765");                    // saturates at 255
    send_line();
    add_text("ANGLE=1");                        // terminator stops the digits
    text_q.push_back(CH_NUL);
    add_text("7");
    send_line();
    add_text("ANGLE=0000000000045");            // longest line that fits
    send_line();
    add_text("ANGLE=00000000000045");           // one byte over, dropped silently
    send_line();
    add_text("LIGHT");                          // next line starts clean
    send_line();
    text_q.push_back(8'hFF);
    text_q.push_back(CH_NUL);
    send_line();

    // register extremes
    set_config(16'h0000, 16'hFFFF, 16'd1);      // pulse saturates
    add_text("ANGLE=2");
    send_line();
    add_text("ANGLE=0");
    send_line();
    set_config(16'd3000, 16'd1000, ANGLE_FS_RST);  // maximum below minimum
    add_text("ANGLE=90");
    send_line();
    set_config(PULSE_MIN_RST, PULSE_MAX_RST, 16'd0);  // full scale of zero
    add_text("ANGLE=2");
    send_line();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_text("ANGLE=180");
    send_line();

    // random part, a new register setting per phase
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES - 1) begin
        steady = 1'b1;
        set_config(PULSE_MIN_RST, PULSE_MAX_RST, ANGLE_FS_RST);
      end else if ($urandom_range(0, 2) == 0) begin
        set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
      end else begin
        lo = $urandom_range(0, 3000);
        set_config(lo, lo + $urandom_range(0, 4000), $urandom_range(1, 360));
      end
      target = bytes_sent + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_sent < target) random_line();
    end

    // drain: every expected result in, then let the block settle
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d bytes under %0d register settings", bytes_sent, settings);
    $display("results: %0d light, %0d pulse, %0d angles stored",
             light_seen, pulse_seen, stored_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
